// ----- rtl/sorted_table_binary_search_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table binary search
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define STBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Types, codes and the microprogram of the sorted table binary search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stbs_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic REG_TABLE_LENGTH = 1'b0;

  localparam int LenW = 9;
  localparam int WordW = 32;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE    = 3'd0;
  localparam step_t STEP_DECODE  = 3'd1;
  localparam step_t STEP_READ    = 3'd2;
  localparam step_t STEP_COMPARE = 3'd3;
  localparam step_t STEP_EMIT    = 3'd4;
  localparam step_t STEP_WRITE   = 3'd5;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_READ,
    ACT_PROBE,
    ACT_EMIT,
    ACT_WRITE
  } act_e;

  typedef enum logic [2:0] {
    COND_NOT_START,
    COND_IS_WRITE,
    COND_LEN_ZERO,
    COND_NOT_EQUAL,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic is_write;
    logic len_zero;
    logic not_equal;
  } status_t;

  // Jump to target when the condition holds, else advance.
  function automatic uword_t urom(input step_t step);
    uword_t uw;
    unique case (step)
      STEP_IDLE:    uw = '{act: ACT_NONE,  cond: COND_NOT_START, target: STEP_IDLE};
      STEP_DECODE:  uw = '{act: ACT_LOAD,  cond: COND_IS_WRITE,  target: STEP_WRITE};
      STEP_READ:    uw = '{act: ACT_READ,  cond: COND_LEN_ZERO,  target: STEP_EMIT};
      STEP_COMPARE: uw = '{act: ACT_PROBE, cond: COND_NOT_EQUAL, target: STEP_READ};
      STEP_EMIT:    uw = '{act: ACT_EMIT,  cond: COND_ALWAYS,    target: STEP_IDLE};
      STEP_WRITE:   uw = '{act: ACT_WRITE, cond: COND_ALWAYS,    target: STEP_IDLE};
      default:      uw = '{act: ACT_NONE,  cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return uw;
  endfunction

endpackage

// ----- rtl/stbs_seq.sv -----
// ----------------------------------------------------------------------------
// stbs_seq
// Step counter and microprogram lookup with conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stbs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stbs_pkg::status_t status_i,
  output stbs_pkg::uword_t  uword_o,
  output logic              busy_o
);

  stbs_pkg::step_t  step_q, step_d;
  stbs_pkg::uword_t uw;
  logic             cond_true;

  assign uw      = stbs_pkg::urom(step_q);
  assign uword_o = uw;
  assign busy_o  = (step_q != stbs_pkg::STEP_IDLE);

  always_comb begin
    unique case (uw.cond)
      stbs_pkg::COND_NOT_START: cond_true = !status_i.start;
      stbs_pkg::COND_IS_WRITE:  cond_true = status_i.is_write;
      stbs_pkg::COND_LEN_ZERO:  cond_true = status_i.len_zero;
      stbs_pkg::COND_NOT_EQUAL: cond_true = status_i.not_equal;
      stbs_pkg::COND_ALWAYS:    cond_true = 1'b1;
      default:                  cond_true = 1'b1;
    endcase
    step_d = cond_true ? uw.target : step_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= stbs_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed words with a microcoded binary search over it.
// ----------------------------------------------------------------------------
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+--------------------------------
//  command  | start, busy (word on start&!busy) | op_i, index_i, value_i
//  result   | done_o, one cycle, no backpressure| found_o, position_o
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A write keeps busy high through the DECODE and WRITE steps. A search keeps
// busy high from DECODE through EMIT over P probes, P <= log2(TABLE_DEPTH)+1;
// each probe is a table read followed by a compare on the single table port.
// done_o is high for one cycle, the first cycle with busy low. Reset clears
// control and the length register; table contents stay undefined until
// written. No clearing pass; the result side cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [7:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic               found_o,
  output logic [8:0]         position_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = (AddrW + 1 > stbs_pkg::LenW) ? AddrW + 1 : stbs_pkg::LenW;
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  stbs_pkg::uword_t  uw;
  stbs_pkg::status_t status;

  logic [stbs_pkg::LenW-1:0] table_length_q;
  logic                      op_q;
  logic [7:0]                index_q;
  logic signed [31:0]        key_q;
  logic signed [31:0]        rdata_q;
  logic [CntW-1:0]           base_q, len_q, probe_q;
  logic                      found_q;
  logic [8:0]                position_q;
  logic                      done_q;

  logic [31:0]     mem_q [TABLE_DEPTH];
  logic            accept;
  logic            cfg_write;
  logic [CntW-1:0] len_cfg, len_sat, probe, probe_next, index_wide;
  logic            key_less;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == stbs_pkg::REG_TABLE_LENGTH)
                     ? 32'(table_length_q) : 32'd0;

  assign accept     = start && !busy;
  assign len_cfg    = CntW'(table_length_q);
  assign len_sat    = (len_cfg > DepthC) ? DepthC : len_cfg;
  assign probe      = base_q + ((len_q - CntW'(1)) >> 1);
  assign probe_next = probe_q + CntW'(1);
  assign index_wide = CntW'(index_q);
  assign key_less   = key_q < rdata_q;

  assign status.start     = start;
  assign status.is_write  = (op_q == stbs_pkg::OP_WRITE);
  assign status.len_zero  = (len_q == '0);
  assign status.not_equal = (key_q != rdata_q);

  stbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uw),
    .busy_o   (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
      done_q         <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == stbs_pkg::REG_TABLE_LENGTH) begin
        table_length_q <= pwdata[stbs_pkg::LenW-1:0];
      end
      done_q <= (uw.act == stbs_pkg::ACT_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      index_q <= index_i;
      key_q   <= value_i;
    end
    unique case (uw.act)
      stbs_pkg::ACT_LOAD: begin
        base_q     <= '0;
        len_q      <= len_sat;
        found_q    <= 1'b0;
        position_q <= '0;
      end
      stbs_pkg::ACT_READ: begin
        probe_q <= probe;
      end
      stbs_pkg::ACT_PROBE: begin
        if (!status.not_equal) begin
          found_q    <= 1'b1;
          position_q <= probe_next[8:0];
        end else begin
          len_q <= len_q >> 1;
          if (!key_less) begin
            base_q <= probe_next;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (uw.act == stbs_pkg::ACT_WRITE && index_wide < DepthC) begin
      mem_q[index_wide[AddrW-1:0]] <= key_q;
    end
    if (uw.act == stbs_pkg::ACT_READ) begin
      rdata_q <= mem_q[probe[AddrW-1:0]];
    end
  end

  assign done_o     = done_q;
  assign found_o    = found_q;
  assign position_o = position_q;

endmodule

// ----- rtl/stbs_checker.sv -----
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks on the sorted table binary search, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       found_o,
  input logic [8:0] position_o
);

  `STBS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "no busy after word")
  `STBS_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  `STBS_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result held twice")
  `STBS_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, done_o && !found_o, position_o == 9'd0, "miss pos")
  `STBS_ASSERT_NOW(a_hit_pos, clk_i, rst_ni, done_o && found_o, position_o != 9'd0, "hit pos")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .found_o    (found_o),
  .position_o (position_o)
);
